// File: src/ias_pkg.sv
// Shared types, constants and lookup tables for the ignition advance / spark trigger block.
package ias_pkg;

  localparam int IAS_TEETH_PER_REV = 20;
  localparam int DEG_PER_REV       = 360;
  localparam int CRANK_DEG         = 3;
  localparam int TEMP_HOT          = 98;
  localparam int TEMP_HOT_BIN      = 10;
  localparam int MAX_ADV_TEETH     = 7;
  localparam int TEMP_EDGES        = 9;
  localparam int RPM_EDGES         = 17;
  localparam int ADV_ROWS          = 18;
  localparam int ADV_COLS          = 11;

  localparam logic [7:0] DWELL_MS_RESET = 8'd7;

  localparam logic MODE_TOOTH = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [8:0] TEMP_EDGE [TEMP_EDGES] = '{
    9'd18, 9'd27, 9'd36, 9'd45, 9'd55, 9'd64, 9'd73, 9'd82, 9'd91
  };

  localparam logic [12:0] RPM_EDGE [RPM_EDGES] = '{
    13'd1000, 13'd1200, 13'd1500, 13'd1700, 13'd2000, 13'd2200,
    13'd2500, 13'd2700, 13'd3000, 13'd3200, 13'd3500, 13'd3700,
    13'd4000, 13'd4500, 13'd5000, 13'd5500, 13'd6000
  };

  // advance in degrees, row = rpm bin, column = coolant bin
  localparam logic [5:0] ADV_DEG [ADV_ROWS][ADV_COLS] = '{
    '{6'd3,  6'd3,  6'd3,  6'd3,  6'd4,  6'd6,  6'd6,  6'd7,  6'd8,  6'd8,  6'd8},
    '{6'd3,  6'd3,  6'd3,  6'd4,  6'd5,  6'd8,  6'd8,  6'd8,  6'd10, 6'd10, 6'd10},
    '{6'd5,  6'd5,  6'd5,  6'd5,  6'd6,  6'd9,  6'd9,  6'd10, 6'd11, 6'd12, 6'd12},
    '{6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd10, 6'd10, 6'd11, 6'd13, 6'd14, 6'd14},
    '{6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd11, 6'd11, 6'd12, 6'd14, 6'd15, 6'd15},
    '{6'd12, 6'd12, 6'd12, 6'd12, 6'd12, 6'd13, 6'd13, 6'd14, 6'd15, 6'd16, 6'd16},
    '{6'd13, 6'd14, 6'd14, 6'd14, 6'd14, 6'd15, 6'd15, 6'd16, 6'd17, 6'd18, 6'd18},
    '{6'd15, 6'd16, 6'd16, 6'd16, 6'd16, 6'd17, 6'd17, 6'd17, 6'd18, 6'd19, 6'd19},
    '{6'd17, 6'd18, 6'd18, 6'd18, 6'd18, 6'd19, 6'd19, 6'd19, 6'd20, 6'd21, 6'd21},
    '{6'd19, 6'd20, 6'd20, 6'd20, 6'd20, 6'd21, 6'd21, 6'd21, 6'd22, 6'd23, 6'd23},
    '{6'd21, 6'd22, 6'd22, 6'd22, 6'd22, 6'd23, 6'd23, 6'd23, 6'd24, 6'd25, 6'd25},
    '{6'd23, 6'd24, 6'd24, 6'd24, 6'd24, 6'd25, 6'd25, 6'd25, 6'd26, 6'd27, 6'd27},
    '{6'd25, 6'd26, 6'd26, 6'd26, 6'd26, 6'd27, 6'd27, 6'd27, 6'd28, 6'd29, 6'd29},
    '{6'd26, 6'd28, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29, 6'd29, 6'd30, 6'd31, 6'd31},
    '{6'd28, 6'd30, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd32, 6'd33, 6'd33},
    '{6'd30, 6'd32, 6'd33, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34, 6'd35, 6'd36, 6'd36},
    '{6'd32, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd35, 6'd37, 6'd38, 6'd38},
    '{6'd34, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd36, 6'd38, 6'd39, 6'd39}
  };

  typedef struct packed {
    logic        mode;
    logic [5:0]  tooth;
    logic [12:0] engine_rpm;
    logic [8:0]  coolant_temp;
    logic        cranking;
  } in_t;

  typedef struct packed {
    logic       coil_a;
    logic       coil_b;
    logic [2:0] advance_teeth;
    logic       advance_changed;
  } out_t;

  // firing window decode result
  typedef struct packed {
    logic hit;
    logic coil_b;  // 0: coil for cylinders 1/4, 1: coil for cylinders 2/3
  } fire_t;

endpackage

// File: src/ias_adv_lookup.sv
// Advance lookup: rpm and coolant binning, advance table, degrees to whole teeth.
module ias_adv_lookup import ias_pkg::*; #(
  parameter int TEETH_PER_REV = IAS_TEETH_PER_REV
) (
  input  logic [12:0] engine_rpm,
  input  logic [8:0]  coolant_temp,
  input  logic        cranking,
  output logic [2:0]  advance
);

  localparam int DegPerTooth = DEG_PER_REV / TEETH_PER_REV;

  logic [4:0] rpm_bin;
  logic [3:0] temp_bin;
  logic [5:0] deg;

  // edges are sorted, so the last edge passed gives the bin
  always_comb begin
    rpm_bin = '0;
    for (int i = 0; i < RPM_EDGES; i++) begin
      if (engine_rpm >= RPM_EDGE[i]) rpm_bin = 5'(i + 1);
    end
  end

  always_comb begin
    temp_bin = '0;
    for (int i = 0; i < TEMP_EDGES; i++) begin
      if (coolant_temp >= TEMP_EDGE[i]) temp_bin = 4'(i + 1);
    end
    if (32'(coolant_temp) >= TEMP_HOT) temp_bin = 4'(TEMP_HOT_BIN);
  end

  assign deg = cranking ? 6'(CRANK_DEG) : ADV_DEG[rpm_bin][temp_bin];

  // truncating divide by a constant: count the tooth multiples reached, cap at max
  always_comb begin
    advance = '0;
    for (int k = 1; k <= MAX_ADV_TEETH; k++) begin
      if (32'(deg) >= k * DegPerTooth) advance = 3'(k);
    end
  end

endmodule

// File: src/ias_window.sv
// Firing window decode: four two-tooth windows, each starting the advance before a quarter mark.
module ias_window import ias_pkg::*; #(
  parameter int TEETH_PER_REV = IAS_TEETH_PER_REV
) (
  input  logic [5:0] tooth,
  input  logic [2:0] advance,
  output fire_t      fire
);

  localparam int Quarter = TEETH_PER_REV / 4;
  localparam logic [6:0] Mark1 = 7'(Quarter);
  localparam logic [6:0] Mark2 = 7'(TEETH_PER_REV / 2);
  localparam logic [6:0] Mark3 = 7'(Quarter * 3);
  localparam logic [6:0] Mark4 = 7'(TEETH_PER_REV);

  logic [6:0] pos;
  logic       hit1, hit2, hit3, hit4;

  // tooth in [mark-adv, mark-adv+1]  <=>  tooth+adv is mark or mark+1
  assign pos  = {1'b0, tooth} + {4'b0, advance};
  assign hit1 = (pos == Mark1) || (pos == Mark1 + 7'd1);
  assign hit2 = (pos == Mark2) || (pos == Mark2 + 7'd1);
  assign hit3 = (pos == Mark3) || (pos == Mark3 + 7'd1);
  assign hit4 = (pos == Mark4) || (pos == Mark4 + 7'd1);

  always_comb begin
    fire = '0;
    if (hit1) begin
      fire.hit = 1'b1;
    end else if (hit2) begin
      fire.hit    = 1'b1;
      fire.coil_b = 1'b1;
    end else if (hit3) begin
      fire.hit = 1'b1;
    end else if (hit4) begin
      fire.hit    = 1'b1;
      fire.coil_b = 1'b1;
    end
  end

endmodule

// File: src/ignition_advance_spark_trigger.sv
// Ignition advance lookup and wasted-spark coil trigger, one result word per input word.
//
// Each input word is either a crank tooth event (mode 0) or a 1 ms tick (mode 1),
// and each produces exactly one result word carrying both coil levels, the
// current advance in whole teeth and a flag saying whether this tooth event
// changed the advance. The design is two register stages: the input word is
// captured, then one pass of logic (rpm/coolant binning, the 18x11 advance
// table, the degree-to-tooth conversion, the four firing windows and the dwell
// timer) updates the engine state and loads the result register. A new word is
// accepted every clock while in_ready is high; the result register is loaded from
// the input stage unless the output side is stalled. in_ready drops only when both
// stages hold words and the result is not being taken. dwell_ms is written
// through cfg_we/cfg_data (reset value 7) and must only change while no word is
// in flight. TEETH_PER_REV sets the tooth pitch (360/TEETH_PER_REV degrees) and
// the quarter-revolution window marks.
module ignition_advance_spark_trigger import ias_pkg::*; #(
  parameter int TEETH_PER_REV = IAS_TEETH_PER_REV
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  // input stage
  logic s1_valid;
  in_t  s1_data;
  logic s2_free;
  logic step;

  // engine state
  logic [7:0] dwell_ms;
  logic       coil_a_level, coil_a_level_next;
  logic       coil_b_level, coil_b_level_next;
  logic       dwell_active, dwell_active_next;
  logic [7:0] dwell_elapsed, dwell_elapsed_next;
  logic [2:0] current_advance, current_advance_next;
  logic       changed;

  logic [2:0] lookup_adv;
  fire_t      fire;

  assign s2_free  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_free;
  assign step     = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  ias_adv_lookup #(
    .TEETH_PER_REV(TEETH_PER_REV)
  ) u_lookup (
    .engine_rpm  (s1_data.engine_rpm),
    .coolant_temp(s1_data.coolant_temp),
    .cranking    (s1_data.cranking),
    .advance     (lookup_adv)
  );

  // windows are judged against the freshly looked-up advance
  ias_window #(
    .TEETH_PER_REV(TEETH_PER_REV)
  ) u_window (
    .tooth  (s1_data.tooth),
    .advance(lookup_adv),
    .fire   (fire)
  );

  always_comb begin
    coil_a_level_next    = coil_a_level;
    coil_b_level_next    = coil_b_level;
    dwell_active_next    = dwell_active;
    dwell_elapsed_next   = dwell_elapsed;
    current_advance_next = current_advance;
    changed              = 1'b0;

    if (s1_data.mode == MODE_TICK) begin
      if (dwell_elapsed != 8'hFF) dwell_elapsed_next = dwell_elapsed + 8'd1;
    end else begin
      current_advance_next = lookup_adv;
      changed              = (lookup_adv != current_advance);
      if (fire.hit) begin
        if (fire.coil_b) begin
          coil_b_level_next = 1'b1;
        end else begin
          coil_a_level_next = 1'b1;
        end
        dwell_active_next  = 1'b1;
        dwell_elapsed_next = '0;
      end
    end

    // dwell end applies after ticks and tooth events alike; a zero dwell
    // drops the coil in the same step it fires
    if (dwell_active_next && (dwell_elapsed_next >= dwell_ms)) begin
      dwell_active_next  = 1'b0;
      dwell_elapsed_next = '0;
      coil_a_level_next  = 1'b0;
      coil_b_level_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coil_a_level    <= 1'b0;
      coil_b_level    <= 1'b0;
      dwell_active    <= 1'b0;
      dwell_elapsed   <= '0;
      current_advance <= '0;
    end else if (step) begin
      coil_a_level    <= coil_a_level_next;
      coil_b_level    <= coil_b_level_next;
      dwell_active    <= dwell_active_next;
      dwell_elapsed   <= dwell_elapsed_next;
      current_advance <= current_advance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ms <= DWELL_MS_RESET;
    end else if (cfg_we) begin
      dwell_ms <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.coil_a          <= coil_a_level_next;
      out_data.coil_b          <= coil_b_level_next;
      out_data.advance_teeth   <= current_advance_next;
      out_data.advance_changed <= changed;
    end
  end

endmodule

// File: src/ias_checker.sv
// Port-level checker for the spark trigger, bound to the top level.
module ias_checker import ias_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input out_t out_data,
  input logic out_valid,
  input logic out_ready
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input side only stalls when the result side is blocked
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result side free");

  // an accepted word reaches the result register once the path is free
  a_word_arrives: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted word lost");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind ignition_advance_spark_trigger ias_checker u_ias_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_data (out_data),
  .out_valid(out_valid),
  .out_ready(out_ready)
);

// File: test/tb_ignition_advance_spark_trigger.sv
// Self-checking testbench for the ignition advance and wasted-spark coil trigger.
module tb_ignition_advance_spark_trigger;
  import ias_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Table geometry and timing knobs for this bench
  localparam int TEETH       = IAS_TEETH_PER_REV;
  localparam int DEG_PER_TTH = DEG_PER_REV / TEETH;  // degrees per crank tooth
  localparam int SEQ_TEETH   = TEETH + 2;            // sweep reaches the last window's tail
  localparam int CYCLE_LIMIT = 200_000;              // several times the slowest clean run
  localparam int TAIL_CYCLES = 8;                    // two-stage pipe plus margin
  localparam int PRINT_CAP   = 200;                  // keep a broken run's log readable

  // Which coil, if any, a tooth event fires
  typedef enum logic [1:0] {
    FIRE_NONE,
    FIRE_COIL_A,
    FIRE_COIL_B
  } fire_sel_e;

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic       cfg_we   = 1'b0;
  logic [7:0] cfg_data = '0;

  ignition_advance_spark_trigger #(
    .TEETH_PER_REV(TEETH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predicted engine state, mirrors what the block should hold after reset
  logic [7:0] dwell_ms_cfg = DWELL_MS_RESET;
  logic       coil_a_q     = 1'b0;
  logic       coil_b_q     = 1'b0;
  logic       dwell_on     = 1'b0;
  logic [7:0] dwell_count  = '0;
  logic [2:0] adv_teeth_q  = '0;

  out_t expected_sparks[$];   // one entry per accepted word, oldest first
  int   mismatch_count = 0;
  int   results_seen   = 0;
  int   cycle_count    = 0;

  // Idle/stall control shared between the test tasks and the two sides
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  int hold_cycles = 0;        // one-shot long receiver stall, picked up by the receiver

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake locks up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_sparks.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Predict the result word for one accepted input word and advance the state.
  function automatic out_t predict_spark(in_t w);
    out_t       r;
    logic [2:0] prev_adv;
    logic [5:0] deg;
    int         tbin;
    int         rbin;
    int         teeth;
    int         lo;
    int         marks [4];
    fire_sel_e  fire;
    r        = '0;
    fire     = FIRE_NONE;
    prev_adv = adv_teeth_q;
    if (w.mode == MODE_TICK) begin
      // tick only advances the dwell timer, saturating
      if (dwell_count != 8'hFF) dwell_count = dwell_count + 8'd1;
    end else begin
      // coolant bin: hot engines jump straight to the last column
      tbin = TEMP_EDGES;
      if (w.coolant_temp >= TEMP_HOT) begin
        tbin = TEMP_HOT_BIN;
      end else begin
        for (int i = TEMP_EDGES - 1; i >= 0; i--)
          if (w.coolant_temp < TEMP_EDGE[i]) tbin = i;
      end
      // rpm bin: first edge above the speed, else the last row
      rbin = RPM_EDGES;
      for (int i = RPM_EDGES - 1; i >= 0; i--)
        if (w.engine_rpm < RPM_EDGE[i]) rbin = i;

      deg   = w.cranking ? 6'(CRANK_DEG) : ADV_DEG[rbin][tbin];
      teeth = int'(deg) / DEG_PER_TTH;
      if (teeth > MAX_ADV_TEETH) teeth = MAX_ADV_TEETH;
      adv_teeth_q = 3'(teeth);
      r.advance_changed = (prev_adv != adv_teeth_q);

      // Quarter-rev marks; the earliest matching window wins, so scan backwards
      marks[0] = TEETH / 4;
      marks[1] = TEETH / 2;
      marks[2] = (TEETH / 4) * 3;
      marks[3] = TEETH;
      for (int k = 3; k >= 0; k--) begin
        lo = marks[k] - teeth;
        if (int'(w.tooth) >= lo && int'(w.tooth) <= lo + 1)
          fire = (k % 2 == 0) ? FIRE_COIL_A : FIRE_COIL_B;
      end
      if (fire != FIRE_NONE) begin
        if (fire == FIRE_COIL_A) coil_a_q = 1'b1;
        else coil_b_q = 1'b1;
        dwell_on    = 1'b1;
        dwell_count = '0;
      end
    end
    // dwell expiry applies after ticks and tooth events alike
    if (dwell_on && dwell_count >= dwell_ms_cfg) begin
      dwell_on    = 1'b0;
      dwell_count = '0;
      coil_a_q    = 1'b0;
      coil_b_q    = 1'b0;
    end
    r.coil_a        = coil_a_q;
    r.coil_b        = coil_b_q;
    r.advance_teeth = adv_teeth_q;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
  endtask

  task automatic check_spark(out_t got);
    out_t want;
    if (expected_sparks.size() == 0) begin
      report_mismatch($sformatf("word %h arrived with nothing expected", got));
      return;
    end
    want = expected_sparks.pop_front();
    if (got.coil_a !== want.coil_a)
      report_mismatch($sformatf("coil_a got %b want %b", got.coil_a, want.coil_a));
    if (got.coil_b !== want.coil_b)
      report_mismatch($sformatf("coil_b got %b want %b", got.coil_b, want.coil_b));
    if (got.advance_teeth !== want.advance_teeth)
      report_mismatch($sformatf("advance_teeth got %0d want %0d",
                                got.advance_teeth, want.advance_teeth));
    if (got.advance_changed !== want.advance_changed)
      report_mismatch($sformatf("advance_changed got %b want %b",
                                got.advance_changed, want.advance_changed));
  endtask

  // Receiver: random stall before each word while rx_idle is set, plus an optional long hold-off.
  // Sampling right after the edge sees pre-edge values of valid/ready/data.
  initial begin : result_sink
    int gap;
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      results_seen++;
      check_spark(out_data);
    end
  end

  function automatic in_t tooth_word(int tooth, int rpm, int temp, bit crank);
    in_t w;
    w.mode         = MODE_TOOTH;
    w.tooth        = 6'(tooth);
    w.engine_rpm   = 13'(rpm);
    w.coolant_temp = 9'(temp);
    w.cranking     = crank;
    return w;
  endfunction

  // Ticks carry junk in the other fields; the block must ignore it
  function automatic in_t tick_word();
    in_t w;
    w.mode         = MODE_TICK;
    w.tooth        = 6'($urandom);
    w.engine_rpm   = 13'($urandom);
    w.coolant_temp = 9'($urandom_range(0, 500));
    w.cranking     = 1'($urandom);
    return w;
  endfunction

  // Offer one word and hold it until taken. Valid is left high on return so a
  // back-to-back word needs only one assignment in the next call.
  task automatic send_word(in_t w);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_sparks.push_back(predict_spark(w));
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sparks.size() != 0);
  endtask

  // Only called with nothing in flight
  task automatic write_dwell(logic [7:0] ms);
    cfg_we   <= 1'b1;
    cfg_data <= ms;
    @(posedge clk);
    cfg_we       <= 1'b0;
    dwell_ms_cfg  = ms;
  endtask

  // Mostly a rotating crank with ticks mixed in; the rest is noise teeth
  // and junk conditions. Conditions are held for about one revolution.
  task automatic run_engine_items(int count, bit vary_idle);
    in_t w;
    int  pos;
    int  rpm_now;
    int  temp_now;
    int  k;
    int  sel;
    bit  crank_now;
    pos = $urandom_range(0, SEQ_TEETH - 1);
    for (int i = 0; i < count; i++) begin
      if (vary_idle && i % 40 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if (i % SEQ_TEETH == 0) begin
        // bias toward bin edges so both sides of each boundary get hit
        k = $urandom_range(0, RPM_EDGES - 1);
        rpm_now = $urandom_range(0, 1) ? int'(RPM_EDGE[k]) - $urandom_range(0, 1)
                                       : $urandom_range(0, 8191);
        k = $urandom_range(0, TEMP_EDGES);
        if ($urandom_range(0, 1))
          temp_now = $urandom_range(0, 500);
        else if (k == TEMP_EDGES)
          temp_now = TEMP_HOT - $urandom_range(0, 1);
        else
          temp_now = int'(TEMP_EDGE[k]) - $urandom_range(0, 1);
        crank_now = ($urandom_range(0, 9) == 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        w = tick_word();
      end else if (sel < 85) begin
        w   = tooth_word(pos, rpm_now, temp_now, crank_now);
        pos = (pos + 1) % SEQ_TEETH;
      end else begin
        w = tooth_word($urandom_range(0, 63), $urandom_range(0, 8191),
                       $urandom_range(0, 500), 1'($urandom));
      end
      send_word(w);
    end
  endtask

  // Hand-picked words at the reset dwell, then a zero dwell
  task automatic test_directed_cases();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word(tooth_word(5, 0, 0, 0));        // first-quarter window at zero advance: coil A
    repeat (3) send_word(tick_word());
    send_word(tooth_word(10, 0, 0, 0));       // half-rev window: coil B joins, dwell restarts
    repeat (7) send_word(tick_word());        // seventh tick hits reset dwell, coils drop
    send_word(tooth_word(63, 8191, 500, 0));  // far end of table, advance jumps, no window
    send_word(tooth_word(18, 6000, 98, 0));   // full-rev window shifted by the advance
    send_word(tooth_word(3, 5000, 91, 0));    // first window shifted to its lowest tooth
    send_word(tooth_word(9, 3000, 50, 0));    // mid-table advance, half-rev window
    send_word(tooth_word(14, 8191, 500, 1));  // cranking overrides the table
    send_word(tooth_word(21, 999, 17, 0));    // tail tooth of the full-rev window
    send_word(tooth_word(0, 1000, 97, 0));    // just below the hot-engine column
    wait_all_results();
    // zero dwell: the coil fires and drops within the same word
    write_dwell(8'd0);
    send_word(tooth_word(16, 8191, 500, 1));
    send_word(tooth_word(11, 0, 0, 0));
    wait_all_results();
  endtask

  // Random engine traffic across a range of dwell settings
  task automatic test_random_dwell_sweep();
    write_dwell(8'd1);
    run_engine_items(320, 1'b1);
    wait_all_results();
    write_dwell(8'd255);
    run_engine_items(160, 1'b1);
    wait_all_results();
    write_dwell(8'd0);
    run_engine_items(100, 1'b1);
    wait_all_results();
    write_dwell(8'($urandom_range(2, 20)));
    run_engine_items(320, 1'b1);
    wait_all_results();
    write_dwell(DWELL_MS_RESET);
    run_engine_items(250, 1'b1);
    wait_all_results();
  endtask

  // Sink stalls for a long stretch while words go in back to back,
  // so the pipe fills and in_ready has to drop
  task automatic test_backpressure();
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    hold_cycles = 80;
    run_engine_items(40, 1'b0);
    wait_all_results();
  endtask

  // Sender goes quiet until everything is back, then resumes
  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_engine_items(30, 1'b0);
    wait_all_results();
    run_engine_items(30, 1'b1);
    wait_all_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_dwell_sweep();
    test_backpressure();
    test_sender_pause();
    // let any stray result word show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sparks.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_sparks.size()));
    if (mismatch_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
